[design/euler_to_rotation_matrix_core_defines.svh]
// ----------------------------------------------------------------------------
// euler to rotation matrix assertion macros
// shared concurrent assertion forms used by the core modules
// ----------------------------------------------------------------------------
`ifndef EULER_TO_ROTATION_MATRIX_CORE_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_DEFINES_SVH

// a condition implies a consequence on the same edge
`define E2R_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// a condition implies a consequence on the next edge
`define E2R_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[design/e2r_pkg.sv]
// ----------------------------------------------------------------------------
// e2r_pkg
// types, constants and arctangent table for the euler to matrix core
// ----------------------------------------------------------------------------
`default_nettype none
package e2r_pkg;

  localparam int ANGLE_WIDTH_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STAGES_DEF  = 16;

  localparam int IW = 34;  // q30 working width, headroom for +-pi
  localparam int AW = ANGLE_WIDTH_DEF;
  localparam int OW = COEF_FRAC_BITS_DEF + 2;

  localparam logic signed [IW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [IW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [IW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [IW-1:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic signed [AW-1:0] yaw_angle;
    logic signed [AW-1:0] pitch_angle;
    logic signed [AW-1:0] roll_angle;
  } in_t;

  typedef struct packed {
    logic signed [OW-1:0] m00;
    logic signed [OW-1:0] m01;
    logic signed [OW-1:0] m02;
    logic signed [OW-1:0] m10;
    logic signed [OW-1:0] m11;
    logic signed [OW-1:0] m12;
    logic signed [OW-1:0] m20;
    logic signed [OW-1:0] m21;
    logic signed [OW-1:0] m22;
  } out_t;

  function automatic logic signed [IW-1:0] atan_q30(input logic [4:0] i);
    logic signed [IW-1:0] r;
    case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd31: r = 34'sd0;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [IW-1:0] clamp1(input logic signed [IW+1:0] v);
    logic signed [IW-1:0] r;
    if (v > 36'(ONE_Q30)) r = ONE_Q30;
    else if (v < -36'(ONE_Q30)) r = -ONE_Q30;
    else r = IW'(v);
    return r;
  endfunction

  // round half up product of two q30 values (|a|,|b| <= 1)
  function automatic logic signed [IW-1:0] qmul(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    logic signed [2*IW-1:0] p;
    p = (2*IW)'(a) * (2*IW)'(b) + (68'sd1 <<< 29);
    return IW'(p >>> 30);
  endfunction

endpackage
`default_nettype wire

[design/euler_to_rotation_matrix_core.sv]
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// euler angles to 3x3 rotation matrix through a half-angle quaternion
//
//   channel | direction | payload
//   in_     | input     | yaw, pitch, roll q2.13
//   out_    | output    | m00..m22 q1.14
//
// fully pipelined: one transfer per cycle unless the output stalls; registers are
// the cordic stages plus entry, three quaternion and three matrix stages, out reg
// the whole pipe advances when the output register is empty or being taken
// synchronous active-low reset clears only the valid bits
// ----------------------------------------------------------------------------
`default_nettype none
`include "euler_to_rotation_matrix_core_defines.svh"
module euler_to_rotation_matrix_core #(
  parameter int CORDIC_STAGES  = e2r_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire e2r_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output e2r_pkg::out_t      out_data
);
  localparam int ANGLE_WIDTH    = e2r_pkg::ANGLE_WIDTH_DEF;
  localparam int COEF_FRAC_BITS = e2r_pkg::COEF_FRAC_BITS_DEF;
  localparam int IW  = e2r_pkg::IW;
  localparam int LAT = 6;  // quaternion and matrix stages after cordic
  localparam int OW  = COEF_FRAC_BITS + 2;

  logic en;
  logic signed [IW-1:0] sy, cy, sp, cp, sr, cr, qx, qy, qz, qw;
  logic signed [OW-1:0] m [9];
  logic [LAT-1:0] v_r;
  logic c_vld, c_vld_p, c_vld_r;
  logic out_valid_r;
  e2r_pkg::out_t out_data_r;

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk, .rst_n, .en, .vld_in(in_valid),
    .angle(ANGLE_WIDTH'(in_data.yaw_angle)), .sin_o(sy), .cos_o(cy),
    .vld_o(c_vld));
  e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk, .rst_n, .en, .vld_in(in_valid),
    .angle(ANGLE_WIDTH'(in_data.pitch_angle)), .sin_o(sp), .cos_o(cp),
    .vld_o(c_vld_p));
  e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk, .rst_n, .en, .vld_in(in_valid),
    .angle(ANGLE_WIDTH'(in_data.roll_angle)), .sin_o(sr), .cos_o(cr),
    .vld_o(c_vld_r));

  e2r_quat u_quat (.clk, .en, .sy, .cy, .sp, .cp, .sr, .cr, .qx, .qy, .qz, .qw);
  e2r_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mat (
    .clk, .en, .qx, .qy, .qz, .qw, .m);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[LAT-2:0], c_vld};
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.m00 <= 16'(m[0]);
      out_data_r.m01 <= 16'(m[1]);
      out_data_r.m02 <= 16'(m[2]);
      out_data_r.m10 <= 16'(m[3]);
      out_data_r.m11 <= 16'(m[4]);
      out_data_r.m12 <= 16'(m[5]);
      out_data_r.m20 <= 16'(m[6]);
      out_data_r.m21 <= 16'(m[7]);
      out_data_r.m22 <= 16'(m[8]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `E2R_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data))
  `E2R_ASSERT_IMPL(a_ready, clk, rst_n, !out_valid, in_ready)
  `E2R_ASSERT_IMPL(a_diag, clk, rst_n, out_valid,
                   out_data.m00 <= 16'sd16384 && out_data.m00 >= -16'sd16384)
  `E2R_ASSERT_IMPL(a_lane_sync, clk, rst_n, 1'b1,
                   c_vld == c_vld_p && c_vld == c_vld_r)
endmodule
`default_nettype wire

[design/e2r_cordic.sv]
// ----------------------------------------------------------------------------
// e2r_cordic
// pipelined rotation cordic, one register stage per iteration, sin/cos of
// half angle in q30
// ----------------------------------------------------------------------------
`default_nettype none
`include "euler_to_rotation_matrix_core_defines.svh"
module e2r_cordic #(
  parameter int ANGLE_WIDTH   = e2r_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 en,
  input  wire logic                                 vld_in,
  input  wire logic signed [ANGLE_WIDTH-1:0]        angle,
  output logic signed [e2r_pkg::IW-1:0]             sin_o,
  output logic signed [e2r_pkg::IW-1:0]             cos_o,
  output logic                                      vld_o
);
  localparam int N  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int IW = e2r_pkg::IW;

  logic signed [IW-1:0] x_r [N+1];
  logic signed [IW-1:0] y_r [N+1];
  logic signed [IW-1:0] z_r [N+1];
  logic                 neg_r [N+1];
  logic                 v_r [N+1];

  logic signed [IW-1:0] z0;
  always_comb begin
    z0 = IW'(angle) <<< (32 - ANGLE_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_in;
    end
    if (en) begin
      x_r[0] <= e2r_pkg::GAIN_Q30;
      y_r[0] <= '0;
      if (z0 > e2r_pkg::HALF_PI_Q30) begin
        z_r[0] <= z0 - e2r_pkg::PI_Q30; neg_r[0] <= 1'b1;
      end else if (z0 < -e2r_pkg::HALF_PI_Q30) begin
        z_r[0] <= z0 + e2r_pkg::PI_Q30; neg_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z0; neg_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][IW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - e2r_pkg::atan_q30(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + e2r_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  always_comb begin
    sin_o = e2r_pkg::clamp1((IW+2)'(neg_r[N] ? -y_r[N] : y_r[N]));
    cos_o = e2r_pkg::clamp1((IW+2)'(neg_r[N] ? -x_r[N] : x_r[N]));
  end

  assign vld_o = v_r[N];

  `E2R_ASSERT_NEXT(a_vld_flow, clk, rst_n, en && vld_in, v_r[0])
  `E2R_ASSERT_NEXT(a_hold, clk, rst_n, !en, $stable(v_r[N]))
  `E2R_ASSERT_IMPL(a_sin_rng, clk, rst_n, v_r[N],
                   sin_o <= e2r_pkg::ONE_Q30 && sin_o >= -e2r_pkg::ONE_Q30)
endmodule
`default_nettype wire

[design/e2r_quat.sv]
// ----------------------------------------------------------------------------
// e2r_quat
// quaternion from half-angle sin/cos, two product stages and a sum stage
// ----------------------------------------------------------------------------
`default_nettype none
module e2r_quat (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [e2r_pkg::IW-1:0] sy, cy, sp, cp, sr, cr,
  output logic signed [e2r_pkg::IW-1:0]     qx, qy, qz, qw
);
  localparam int IW = e2r_pkg::IW;
  logic signed [IW-1:0] cysp_r, sycp_r, cycp_r, sysp_r, sr_r, cr_r;
  logic signed [IW-1:0] t0_r, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r;
  logic signed [IW-1:0] qx_r, qy_r, qz_r, qw_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cysp_r <= e2r_pkg::qmul(cy, sp);
      sycp_r <= e2r_pkg::qmul(sy, cp);
      cycp_r <= e2r_pkg::qmul(cy, cp);
      sysp_r <= e2r_pkg::qmul(sy, sp);
      sr_r   <= sr;
      cr_r   <= cr;
      t0_r <= e2r_pkg::qmul(cysp_r, cr_r);
      t1_r <= e2r_pkg::qmul(sycp_r, sr_r);
      t2_r <= e2r_pkg::qmul(sycp_r, cr_r);
      t3_r <= e2r_pkg::qmul(cysp_r, sr_r);
      t4_r <= e2r_pkg::qmul(cycp_r, sr_r);
      t5_r <= e2r_pkg::qmul(sysp_r, cr_r);
      t6_r <= e2r_pkg::qmul(cycp_r, cr_r);
      t7_r <= e2r_pkg::qmul(sysp_r, sr_r);
      qx_r <= e2r_pkg::clamp1((IW+2)'(t0_r) + (IW+2)'(t1_r));
      qy_r <= e2r_pkg::clamp1((IW+2)'(t2_r) - (IW+2)'(t3_r));
      qz_r <= e2r_pkg::clamp1((IW+2)'(t4_r) - (IW+2)'(t5_r));
      qw_r <= e2r_pkg::clamp1((IW+2)'(t6_r) + (IW+2)'(t7_r));
    end
  end
  assign qx = qx_r;
  assign qy = qy_r;
  assign qz = qz_r;
  assign qw = qw_r;
endmodule
`default_nettype wire

[design/e2r_matrix.sv]
// ----------------------------------------------------------------------------
// e2r_matrix
// pairwise quaternion products in q60, sums, rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none
module e2r_matrix #(
  parameter int COEF_FRAC_BITS = e2r_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [e2r_pkg::IW-1:0] qx, qy, qz, qw,
  output logic signed [COEF_FRAC_BITS+1:0]  m [9]
);
  localparam int PW = 64;
  localparam int SH = 60 - COEF_FRAC_BITS;
  localparam int OW = COEF_FRAC_BITS + 2;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, xw_r, yz_r, yw_r, zw_r;
  logic signed [PW-1:0] e_r [9];
  logic signed [PW-1:0] one;
  logic signed [OW-1:0] m_r [9];

  assign one = 64'sd1 <<< 60;

  function automatic logic signed [OW-1:0] to_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] lim;
    lim = 64'sd1 <<< COEF_FRAC_BITS;
    t = (v + (64'sd1 <<< (SH - 1))) >>> SH;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return OW'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= PW'(qx) * PW'(qx);
      yy_r <= PW'(qy) * PW'(qy);
      zz_r <= PW'(qz) * PW'(qz);
      xy_r <= PW'(qx) * PW'(qy);
      xz_r <= PW'(qx) * PW'(qz);
      xw_r <= PW'(qx) * PW'(qw);
      yz_r <= PW'(qy) * PW'(qz);
      yw_r <= PW'(qy) * PW'(qw);
      zw_r <= PW'(qz) * PW'(qw);
      e_r[0] <= one - 2 * (yy_r + zz_r);
      e_r[1] <= 2 * (xy_r + zw_r);
      e_r[2] <= 2 * (xz_r - yw_r);
      e_r[3] <= 2 * (xy_r - zw_r);
      e_r[4] <= one - 2 * (zz_r + xx_r);
      e_r[5] <= 2 * (yz_r + xw_r);
      e_r[6] <= 2 * (xz_r + yw_r);
      e_r[7] <= 2 * (yz_r - xw_r);
      e_r[8] <= one - 2 * (yy_r + xx_r);
      for (int k = 0; k < 9; k++) m_r[k] <= to_out(e_r[k]);
    end
  end
  assign m = m_r;
endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// euler to rotation matrix core testbench
// drives yaw, pitch and roll through the valid/ready input, predicts the nine
// q1.14 matrix entries with a cordic half-angle quaternion model and checks
// every result in order under several sender and receiver idling mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class matrix_scoreboard;
  e2r_pkg::out_t pending_matrices[$];
  int            mismatches = 0;

  localparam longint UNIT  = 64'sd1 << 30;
  localparam longint HPI   = 64'sd1686629713;
  localparam longint PI    = 64'sd3373259426;
  localparam longint GAIN  = 64'sd652032874;

  function longint sat_unit(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  function longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function longint arctan_step(int i);
    longint t[11];
    t = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
          16775851, 8388437, 4194283, 2097149, 1048575};
    if (i < 11) return t[i];
    if (i >= 31) return 0;
    return 64'sd1 << (30 - i);
  endfunction

  function void half_angle_trig(logic signed [15:0] ang, output longint s,
                                output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 65536;
    x = GAIN;
    y = 0;
    flip = 0;
    if (z > HPI) begin
      z -= PI;
      flip = 1;
    end else if (z < -HPI) begin
      z += PI;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = sat_unit(y);
    c = sat_unit(x);
  endfunction

  function logic signed [15:0] to_q14(longint q60);
    longint v;
    v = (q60 + (64'sd1 << 45)) >>> 46;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  function void note_angles(e2r_pkg::in_t a);
    longint sy, cy, sp, cp, sr, cr, qx, qy, qz, qw, one;
    e2r_pkg::out_t m;
    half_angle_trig(a.yaw_angle, sy, cy);
    half_angle_trig(a.pitch_angle, sp, cp);
    half_angle_trig(a.roll_angle, sr, cr);
    qx = sat_unit(mul_q30(mul_q30(cy, sp), cr) + mul_q30(mul_q30(sy, cp), sr));
    qy = sat_unit(mul_q30(mul_q30(sy, cp), cr) - mul_q30(mul_q30(cy, sp), sr));
    qz = sat_unit(mul_q30(mul_q30(cy, cp), sr) - mul_q30(mul_q30(sy, sp), cr));
    qw = sat_unit(mul_q30(mul_q30(cy, cp), cr) + mul_q30(mul_q30(sy, sp), sr));
    one = 64'sd1 << 60;
    m.m00 = to_q14(one - 2 * (qy * qy + qz * qz));
    m.m01 = to_q14(2 * (qx * qy + qz * qw));
    m.m02 = to_q14(2 * (qx * qz - qy * qw));
    m.m10 = to_q14(2 * (qx * qy - qz * qw));
    m.m11 = to_q14(one - 2 * (qz * qz + qx * qx));
    m.m12 = to_q14(2 * (qy * qz + qx * qw));
    m.m20 = to_q14(2 * (qx * qz + qy * qw));
    m.m21 = to_q14(2 * (qy * qz - qx * qw));
    m.m22 = to_q14(one - 2 * (qy * qy + qx * qx));
    pending_matrices.push_back(m);
  endfunction

  function void check_field(string name, logic signed [15:0] e,
                            logic signed [15:0] g);
    if (e !== g) begin
      $error("%s expected %0d actual %0d", name, e, g);
      mismatches++;
    end
  endfunction

  function void check_matrix(e2r_pkg::out_t g);
    e2r_pkg::out_t e;
    if (pending_matrices.size() == 0) begin
      $error("unexpected result transfer");
      mismatches++;
      return;
    end
    e = pending_matrices.pop_front();
    check_field("m00", e.m00, g.m00);
    check_field("m01", e.m01, g.m01);
    check_field("m02", e.m02, g.m02);
    check_field("m10", e.m10, g.m10);
    check_field("m11", e.m11, g.m11);
    check_field("m12", e.m12, g.m12);
    check_field("m20", e.m20, g.m20);
    check_field("m21", e.m21, g.m21);
    check_field("m22", e.m22, g.m22);
  endfunction
endclass

module testbench;
  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_ready;
  e2r_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 0;
  e2r_pkg::out_t out_data;

  matrix_scoreboard board = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  hold_cycles = 0;
  int  cycle_count = 0;

  euler_to_rotation_matrix_core DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off counted here
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_matrix(out_data);
    if (hold_off && hold_cycles < 200) begin
      hold_cycles <= hold_cycles + 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_angles(logic [15:0] y, logic [15:0] p, logic [15:0] r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{yaw_angle: y, pitch_angle: p, roll_angle: r};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_angles(in_data);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(7))
      0: return 16'h8000 + 16'($urandom_range(3));
      1: return 16'h7fff - 16'($urandom_range(3));
      2: return 16'(25736 + int'($urandom_range(8)) - 4);  // near +pi half-angle fold
      3: return 16'(-25736 + int'($urandom_range(8)) - 4);
      4: return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_angles(pick_angle(), pick_angle(), pick_angle());
  endtask

  logic [15:0] corners[8];
  initial begin
    corners = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff,
                16'd12868, 16'd25736, -16'sd25736};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (corners[i]) send_angles(corners[i], 16'd0, 16'd0);
    foreach (corners[i]) send_angles(16'd0, corners[i], 16'd0);
    foreach (corners[i]) send_angles(16'd0, 16'd0, corners[i]);
    send_angles(16'h7fff, 16'h8000, 16'h7fff);
    random_phase(280, 0, 0);
    random_phase(280, 49, 0);
    hold_off = 1;
    random_phase(280, 0, 49);
    random_phase(280, 29, 29);
    in_valid <= 0;
    while (board.pending_matrices.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
